[rtl/kcl_pkg.sv]
// ----------------------------------------------------------------------------
// kcl_pkg
// Shared key width and key codes for the keypad code lock.
// ----------------------------------------------------------------------------
package kcl_pkg;

  localparam int KEY_W = 8;

  typedef logic [KEY_W-1:0] key_t;

  localparam key_t KEY_NONE  = 8'h00;
  localparam key_t KEY_POUND = 8'h23;
  localparam key_t KEY_STAR  = 8'h2A;
  // Code store resets to the digits counting up from this character.
  localparam key_t KEY_ONE   = 8'h31;

endpackage

[rtl/kcl_if.sv]
// ----------------------------------------------------------------------------
// kcl_in_if / kcl_out_if
// Valid/ready channels of the keypad code lock: key ticks in, lock status out.
// ----------------------------------------------------------------------------
interface kcl_in_if
  import kcl_pkg::*;
;
  logic valid;
  logic ready;
  key_t key_char;
  logic inside_button;

  modport source (output valid, output key_char, output inside_button, input ready);
  modport sink   (input valid, input key_char, input inside_button, output ready);
endinterface

interface kcl_out_if;
  logic valid;
  logic ready;
  logic unlocked;
  logic changing_code;

  modport source (output valid, output unlocked, output changing_code, input ready);
  modport sink   (input valid, input unlocked, input changing_code, output ready);
endinterface

[rtl/keypad_code_lock.sv]
// ----------------------------------------------------------------------------
// keypad_code_lock
// Unlock and code-change state machines stepped once per keypad tick.
// ----------------------------------------------------------------------------
//  Channel  Dir  Beat contents
//  in_ch    in   key_char[7:0], inside_button
//  out_ch   out  unlocked, changing_code (one beat per input beat)
//
// Each input beat is handled at the accepting edge: both machines and the code
// store update there and the status beat is registered there.
// A new beat is taken every cycle while the output register is empty or is
// being drained, so throughput is one beat per clock.
// Reset (rst_n low, synchronous) returns both machines to their start state
// and reloads the code store with "12345...". A stalled output holds in_ch.
// ----------------------------------------------------------------------------
module keypad_code_lock
  import kcl_pkg::*;
#(
  parameter int CODE_LENGTH = 5
) (
  input  logic       clk,
  input  logic       rst_n,
  kcl_in_if.sink     in_ch,
  kcl_out_if.source  out_ch
);

  localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CODE_LENGTH - 1);

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [2:0] {
    LK_START, LK_IDLE, LK_OPEN, LK_POUND, LK_WPOUND, LK_GOT, LK_WAIT
  } lock_state_t;

  typedef enum logic [2:0] {
    CH_START, CH_IDLE, CH_ENTRY, CH_PAUSE, CH_HOLD
  } chg_state_t;

  lock_state_t lk_state_r, lk_state_nxt;
  idx_t        lk_n_r, lk_n_nxt;
  chg_state_t  ch_state_r, ch_state_nxt;
  idx_t        ch_n_r, ch_n_nxt;
  logic        out_valid_r;
  logic        out_unlocked_r;
  logic        out_changing_r;

  logic        accept;
  key_t        key;
  logic        button;
  logic        key_none;
  logic        key_pound;
  logic [CODE_LENGTH-1:0] code_eq;   // key equals stored character i
  logic [CODE_LENGTH-1:0] code_zero; // stored character i is zero
  logic        store_en;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign key         = in_ch.key_char;
  assign button      = in_ch.inside_button;
  assign key_none    = (key == KEY_NONE);
  assign key_pound   = (key == KEY_POUND);

  assign out_ch.valid         = out_valid_r;
  assign out_ch.unlocked      = out_unlocked_r;
  assign out_ch.changing_code = out_changing_r;

  // The change machine stores a character on the first tick of a key press.
  assign store_en = accept && (ch_state_r == CH_PAUSE) && !key_none;

  // Code store: each entry is compared with the key in place, so the unlock
  // machine only has to pick one match bit. It sees the code as it stood
  // before this beat's store.
  for (genvar g = 0; g < CODE_LENGTH; g++) begin : g_code
    localparam key_t RST_CHAR = KEY_W'(KEY_ONE + (g % 9));
    key_t code_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        code_r <= RST_CHAR;
      end else if (store_en && (ch_n_r == IDX_W'(g))) begin
        code_r <= key;
      end
    end

    assign code_eq[g]   = (code_r == key);
    assign code_zero[g] = (code_r == KEY_NONE);
  end

  // Unlock machine.
  always_comb begin
    lk_state_nxt = lk_state_r;
    lk_n_nxt     = lk_n_r;
    case (lk_state_r)
      LK_START: lk_state_nxt = LK_IDLE;
      LK_IDLE: begin
        if (key_pound) lk_state_nxt = LK_POUND;
      end
      LK_OPEN: begin
        if (button) lk_state_nxt = LK_IDLE;
      end
      LK_POUND: begin
        lk_state_nxt = (key_none || key_pound) ? LK_WPOUND : LK_IDLE;
      end
      LK_WPOUND: begin
        if (key_none || key_pound) begin
          lk_state_nxt = LK_WPOUND;
        end else if (code_eq[0]) begin
          lk_state_nxt = (CODE_LENGTH == 1) ? LK_OPEN : LK_GOT;
          lk_n_nxt     = IDX_W'(1);
        end else begin
          lk_state_nxt = LK_IDLE;
        end
      end
      LK_GOT: begin
        if (key_pound) begin
          lk_state_nxt = LK_POUND;
        end else if (key_none || code_eq[lk_n_r - 1'b1]) begin
          lk_state_nxt = LK_WAIT;
        end else begin
          lk_state_nxt = LK_IDLE;
        end
      end
      LK_WAIT: begin
        // A release or a held repeat of the last character keeps waiting.
        if (key_pound) begin
          lk_state_nxt = LK_POUND;
        end else if (key_none || code_eq[lk_n_r - 1'b1]) begin
          lk_state_nxt = LK_WAIT;
        end else if (code_eq[lk_n_r]) begin
          lk_state_nxt = (lk_n_r == LAST_IDX) ? LK_OPEN : LK_GOT;
          lk_n_nxt     = IDX_W'(lk_n_r + 1'b1);
        end else begin
          lk_state_nxt = LK_IDLE;
        end
      end
      default: lk_state_nxt = LK_START;
    endcase
  end

  // Change machine.
  always_comb begin
    ch_state_nxt = ch_state_r;
    ch_n_nxt     = ch_n_r;
    case (ch_state_r)
      CH_START: ch_state_nxt = CH_IDLE;
      CH_IDLE: begin
        if ((key == KEY_STAR) && button) ch_state_nxt = CH_ENTRY;
      end
      CH_ENTRY: begin
        if ((key == KEY_STAR) || button) begin
          ch_state_nxt = CH_ENTRY;
        end else if (key_none) begin
          ch_state_nxt = CH_PAUSE;
          ch_n_nxt     = '0;
        end else begin
          ch_state_nxt = CH_IDLE;
        end
      end
      CH_PAUSE: begin
        if (!key_none) begin
          ch_state_nxt = (ch_n_r == LAST_IDX) ? CH_IDLE : CH_HOLD;
          ch_n_nxt     = IDX_W'(ch_n_r + 1'b1);
        end
      end
      CH_HOLD: begin
        if (key_none && !code_zero[ch_n_r - 1'b1]) ch_state_nxt = CH_PAUSE;
      end
      default: ch_state_nxt = CH_START;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lk_state_r     <= LK_START;
      lk_n_r         <= '0;
      ch_state_r     <= CH_START;
      ch_n_r         <= '0;
      out_valid_r    <= 1'b0;
      out_unlocked_r <= 1'b0;
      out_changing_r <= 1'b0;
    end else begin
      if (accept) begin
        lk_state_r     <= lk_state_nxt;
        lk_n_r         <= lk_n_nxt;
        ch_state_r     <= ch_state_nxt;
        ch_n_r         <= ch_n_nxt;
        out_valid_r    <= 1'b1;
        out_unlocked_r <= (lk_state_nxt == LK_OPEN);
        out_changing_r <= (ch_state_nxt != CH_START) && (ch_state_nxt != CH_IDLE);
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
